// ===== rtl/hwd_pkg.sv =====
// Package: shared constants and types for the Huffman tree walk decoder.
package hwd_pkg;

   localparam int TreeEntries = 256;
   localparam int TreeIdxW    = $clog2(TreeEntries);
   localparam int RefW        = 9;
   localparam int QueueDepth  = 2;
   localparam int QPtrW       = $clog2(QueueDepth);
   localparam int QCntW       = $clog2(QueueDepth + 1);

   localparam logic [RefW-1:0] RootReset = 9'd256;
   localparam logic [7:0]      SymCr     = 8'h0D;
   localparam logic [7:0]      SymLf     = 8'h0A;

   localparam logic [1:0] FuncLoad    = 2'd0;
   localparam logic [1:0] FuncDecode  = 2'd1;
   localparam logic [1:0] FuncRestart = 2'd2;

   typedef enum logic [1:0] {
      OpLoad    = 2'd0,
      OpDecode  = 2'd1,
      OpRestart = 2'd2
   } op_type;

   typedef struct packed {
      op_type          op;
      logic [7:0]      node_index;
      logic [RefW-1:0] left_child;
      logic [RefW-1:0] right_child;
      logic [7:0]      data_byte;
      logic [2:0]      skip_bits;
   } qent_type;

   typedef enum logic [2:0] {
      StIdle  = 3'b001,
      StWalk  = 3'b010,
      StFlush = 3'b100
   } state_type;

endpackage

// ===== rtl/hwd_ifs.sv =====
// Interfaces: request, response and configuration channels.
interface hwd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] node_index;
   logic [8:0] left_child;
   logic [8:0] right_child;
   logic [7:0] data_byte;
   logic [2:0] skip_bits;
   modport source (output valid, func, node_index, left_child, right_child, data_byte,
                   skip_bits, input ready);
   modport sink (input valid, func, node_index, left_child, right_child, data_byte,
                 skip_bits, output ready);
endinterface

interface hwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_line;
   logic       last;
   modport source (output valid, symbol, end_of_line, last, input ready);
   modport sink (input valid, symbol, end_of_line, last, output ready);
endinterface

interface hwd_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] root_node;
   modport source (output valid, root_node, input ready);
   modport sink (input valid, root_node, output ready);
endinterface

// ===== rtl/hwd_front.sv =====
// Front end: accepts request transactions, drops unused ones, queues the rest.
module hwd_front import hwd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   hwd_req_if.sink  req,
   output qent_type q_ent,
   output logic     q_valid,
   input  logic     q_ready
);

   logic     hold_ff, hold_in;
   qent_type ent_ff, ent_in;
   logic     accept, keep, in_range;

   assign req.ready = !hold_ff || q_ready;
   assign accept    = req.valid && req.ready;
   assign in_range  = {1'b0, req.node_index} < 9'(TreeEntries);
   assign q_valid   = hold_ff;
   assign q_ent     = ent_ff;

   always_comb begin
      ent_in.node_index  = req.node_index;
      ent_in.left_child  = req.left_child;
      ent_in.right_child = req.right_child;
      ent_in.data_byte   = req.data_byte;
      ent_in.skip_bits   = req.skip_bits;
      ent_in.op          = OpDecode;
      keep               = 1'b0;
      unique case (req.func)
         FuncLoad: begin
            ent_in.op = OpLoad;
            keep      = in_range;
         end
         FuncDecode: begin
            ent_in.op = OpDecode;
            keep      = 1'b1;
         end
         FuncRestart: begin
            ent_in.op = OpRestart;
            keep      = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      hold_in = hold_ff;
      if (accept) begin
         hold_in = keep;
      end else if (q_ready) begin
         hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule

// ===== rtl/hwd_queue.sv =====
// Queue: short FIFO between the front end and the tree walker.
module hwd_queue import hwd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qent_type push_ent,
   input  logic     push_valid,
   output logic     push_ready,
   output qent_type pop_ent,
   output logic     pop_valid,
   input  logic     pop_ready
);

   qent_type         slot_ff [QueueDepth];
   logic [QPtrW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != QCntW'(QueueDepth);
   assign pop_valid  = cnt_ff != '0;
   assign pop_ent    = slot_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_ent;
      end
   end

endmodule

// ===== rtl/hwd_back.sv =====
// Back end: tree memory, bit-serial walk, symbol hold-back and response register.
module hwd_back import hwd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qent_type  q_ent,
   input  logic      q_valid,
   output logic      q_ready,
   hwd_csr_if.sink   csr,
   hwd_rsp_if.source rsp
);

   logic [2*RefW-1:0] mem [TreeEntries];
   logic [2*RefW-1:0] entry_ff;

   state_type       state_ff, state_in;
   logic [RefW-1:0] root_ff;
   logic [RefW-1:0] walk_ff, walk_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [7:0]      byte_ff, byte_in;
   logic            pend_ff, pend_in;
   logic [7:0]      psym_ff, psym_in;
   logic            ovalid_ff, ovalid_in;
   logic [7:0]      osym_ff, osym_in;
   logic            oeol_ff, oeol_in;
   logic            olast_ff, olast_in;

   logic                rd_en, wr_en, rd_in_range;
   logic [RefW-1:0]     rd_ref;
   logic [TreeIdxW-1:0] rd_idx, wr_idx;
   logic                bit_val, is_node, leaf, emit, out_free, push;
   logic [RefW-1:0]     child, next_ref;

   assign csr.ready       = 1'b1;
   assign rsp.valid       = ovalid_ff;
   assign rsp.symbol      = osym_ff;
   assign rsp.end_of_line = oeol_ff;
   assign rsp.last        = olast_ff;

   assign out_free = !ovalid_ff || rsp.ready;
   assign bit_val  = byte_ff[~cnt_ff];
   assign is_node  = walk_ff[RefW-1];
   assign child    = bit_val ? entry_ff[2*RefW-1:RefW] : entry_ff[RefW-1:0];
   assign next_ref = is_node ? child : walk_ff;
   assign leaf     = !next_ref[RefW-1];
   assign emit     = leaf && (next_ref[7:0] != SymCr);

   assign rd_idx      = rd_ref[TreeIdxW-1:0];
   assign rd_in_range = {1'b0, rd_ref[7:0]} < 9'(TreeEntries);
   assign wr_idx      = q_ent.node_index[TreeIdxW-1:0];

   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      cnt_in   = cnt_ff;
      byte_in  = byte_ff;
      pend_in  = pend_ff;
      psym_in  = psym_ff;
      osym_in  = osym_ff;
      olast_in = olast_ff;
      push     = 1'b0;
      q_ready  = 1'b0;
      rd_en    = 1'b0;
      rd_ref   = walk_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         StIdle: begin
            q_ready = 1'b1;
            if (q_valid) begin
               unique case (q_ent.op)
                  OpLoad: wr_en = 1'b1;
                  OpDecode: begin
                     rd_en    = 1'b1;
                     cnt_in   = 3'd0;
                     byte_in  = q_ent.data_byte;
                     state_in = StWalk;
                  end
                  OpRestart: begin
                     rd_en    = 1'b1;
                     rd_ref   = root_ff;
                     walk_in  = root_ff;
                     cnt_in   = q_ent.skip_bits;
                     byte_in  = q_ent.data_byte;
                     state_in = StWalk;
                  end
                  default: ;
               endcase
            end
         end
         StWalk: begin
            // hold the bit while an earlier symbol cannot leave
            if (!(emit && pend_ff && !out_free)) begin
               if (emit) begin
                  if (pend_ff) begin
                     push     = 1'b1;
                     osym_in  = psym_ff;
                     olast_in = 1'b0;
                  end
                  pend_in = 1'b1;
                  psym_in = next_ref[7:0];
               end
               walk_in = leaf ? root_ff : next_ref;
               rd_en   = 1'b1;
               rd_ref  = walk_in;
               cnt_in  = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_in = StFlush;
               end
            end
         end
         StFlush: begin
            if (!pend_ff) begin
               state_in = StIdle;
            end else if (out_free) begin
               push     = 1'b1;
               osym_in  = psym_ff;
               olast_in = 1'b1;
               pend_in  = 1'b0;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      oeol_in   = push ? (osym_in == SymLf) : oeol_ff;
      ovalid_in = push ? 1'b1 : (rsp.ready ? 1'b0 : ovalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         root_ff   <= RootReset;
         walk_ff   <= RootReset;
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_ff   <= walk_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
         if (csr.valid) begin
            root_ff <= csr.root_node;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      byte_ff  <= byte_in;
      psym_ff  <= psym_in;
      osym_ff  <= osym_in;
      oeol_ff  <= oeol_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {q_ent.left_child, q_ent.right_child};
      end
   end

   // the range check covers all 256 entries, so every reference reads a stored entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_ff <= rd_in_range ? mem[rd_idx] : '0;
      end
   end

endmodule

// ===== rtl/huffman_tree_walk_decoder.sv =====
// Top level: Huffman tree walk decoder.
//
//   channel  dir  transaction
//   req_*    in   load tree node / decode byte / restart walk and decode byte
//   rsp_*    out  one decoded symbol with end_of_line and last
//   csr_*    in   root_node write, always ready
//
// A decode transaction does one tree memory read to start the walk, then walks the code
// bits in order (8, fewer after skipped bits), and finally releases the held symbol.
// The walk does one single-port tree memory read per code bit.
// Reset is synchronous and needs no clearing pass.
// A stalled response holds the walk; the front end keeps accepting until the queue fills.
module huffman_tree_walk_decoder import hwd_pkg::*; (
   input logic       clock,
   input logic       reset,
   hwd_req_if.sink   req_chan,
   hwd_rsp_if.source rsp_chan,
   hwd_csr_if.sink   csr_chan
);

   qent_type fq_ent, qb_ent;
   logic     fq_valid, fq_ready, qb_valid, qb_ready;

   hwd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_ent   (fq_ent),
      .q_valid (fq_valid),
      .q_ready (fq_ready)
   );

   hwd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_ent   (fq_ent),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .pop_ent    (qb_ent),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready)
   );

   hwd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_ent   (qb_ent),
      .q_valid (qb_valid),
      .q_ready (qb_ready),
      .csr     (csr_chan),
      .rsp     (rsp_chan)
   );

endmodule

// ===== rtl/hwd_checker.sv =====
// Checker: port-level assertions for the Huffman tree walk decoder.
module hwd_checker import hwd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_symbol,
   input logic       rsp_end_of_line,
   input logic       rsp_last,
   input logic       csr_ready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol)
         && $stable(rsp_end_of_line) && $stable(rsp_last))
      else $error("stalled response changed");

   a_eol_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_end_of_line == (rsp_symbol == SymLf))
      else $error("end_of_line does not match symbol");

   a_no_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_symbol != SymCr)
      else $error("carriage return emitted");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind huffman_tree_walk_decoder hwd_checker u_hwd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_symbol      (rsp_chan.symbol),
   .rsp_end_of_line (rsp_chan.end_of_line),
   .rsp_last        (rsp_chan.last),
   .csr_ready       (csr_chan.ready)
);
